[design/length_prefixed_command_frame_parser_unit_assert.svh]
// Assertion macros shared by the parser RTL.
// Needs nothing else; define ASSERT_OFF to compile the checks out.
`ifndef LENGTH_PREFIXED_COMMAND_FRAME_PARSER_UNIT_ASSERT_SVH
`define LENGTH_PREFIXED_COMMAND_FRAME_PARSER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define LPCF_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("lpcf assertion failed");
`define LPCF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lpcf assertion failed");
`else
`define LPCF_ASSERT(label, clk, rst, prop)
`define LPCF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[design/lpcf_pkg.sv]
// Shared types and constants for the command frame parser.
// Used by the register file, the parser core, the output buffer and the top level.
package lpcf_pkg;

  localparam int MAX_SLOTS = 6;

  typedef enum logic [1:0] {
    ST_RECEIVING = 2'd0,
    ST_COMPLETE  = 2'd1,
    ST_ERROR     = 2'd2
  } status_t;

  localparam logic [2:0] REG_COUNT      = 3'd0;
  localparam logic [2:0] REG_WORD_FIRST = 3'd1;
  localparam logic [2:0] REG_WORD_LAST  = 3'd6;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [4:0] POS_CMD_LAST  = 5'd3;
  localparam logic [4:0] POS_COLON_MAX = 5'd20;
  localparam logic [4:0] POS_SAT       = 5'd21;

  typedef struct packed {
    logic [2:0]                 count;
    logic [MAX_SLOTS-1:0][31:0] words;
  } cfg_t;

  typedef struct packed {
    status_t     frame_status;
    logic [2:0]  command_index;
    logic [15:0] declared_size;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        payload_last;
  } result_t;

endpackage

[design/lpcf_regs.sv]
// APB-style configuration registers: command count and six command words.
// Depends on lpcf_pkg.
module lpcf_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output lpcf_pkg::cfg_t    cfg
);

  logic [2:0]                           count_r;
  logic [lpcf_pkg::MAX_SLOTS-1:0][31:0] words_r;
  logic [2:0]                           idx;
  logic [2:0]                           widx;
  logic                                 wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign widx   = idx - lpcf_pkg::REG_WORD_FIRST;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 3'd0;
      words_r <= '0;
    end else if (wr_en) begin
      if (idx == lpcf_pkg::REG_COUNT) begin
        count_r <= pwdata[2:0];
      end else if (idx inside {[lpcf_pkg::REG_WORD_FIRST:lpcf_pkg::REG_WORD_LAST]}) begin
        words_r[widx] <= pwdata;
      end
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (idx == lpcf_pkg::REG_COUNT) begin
      prdata = {29'd0, count_r};
    end else if (idx inside {[lpcf_pkg::REG_WORD_FIRST:lpcf_pkg::REG_WORD_LAST]}) begin
      prdata = words_r[widx];
    end
  end

  assign cfg.count = count_r;
  assign cfg.words = words_r;

endmodule

[design/lpcf_core.sv]
// Parser core: frame state registers and the per-byte next-state and result logic.
// Depends on lpcf_pkg and the assertion macro header.
`include "length_prefixed_command_frame_parser_unit_assert.svh"
module lpcf_core #(
  parameter int SIZE_WIDTH    = 16,
  parameter int COMMAND_SLOTS = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              restart,
  input  lpcf_pkg::cfg_t    cfg,
  output lpcf_pkg::result_t result
);

  typedef enum logic [2:0] {
    PH_COMMAND,
    PH_SEPARATOR,
    PH_SIZE_LEAD,
    PH_SIZE_DIGITS,
    PH_PAYLOAD,
    PH_DONE,
    PH_ERROR
  } phase_t;

  localparam int AW = SIZE_WIDTH + 4;

  phase_t                phase_r, phase_b, phase_nxt;
  logic [4:0]            pos_r, pos_b, pos_nxt;
  logic [31:0]           shift_r, shift_b, shift_nxt;
  logic [SIZE_WIDTH-1:0] acc_r, acc_b, acc_nxt;
  logic                  neg_r, neg_b, neg_nxt;
  logic                  stop_r, stop_b, stop_nxt;
  logic                  ovf_r, ovf_b, ovf_nxt;
  logic [SIZE_WIDTH-1:0] rem_r, rem_b, rem_nxt;
  logic [2:0]            idx_r, idx_b, idx_nxt;

  logic [2:0]            limit;
  logic                  hit;
  logic [2:0]            hit_idx;
  logic [31:0]           shift_in;
  logic [3:0]            digit;
  logic [AW-1:0]         acc_sum;
  logic                  sum_ovf;
  logic                  is_digit;
  logic                  is_space;
  logic [SIZE_WIDTH+15:0] acc_pad;
  logic                  pv;
  logic                  pl;
  lpcf_pkg::status_t     frame_st;

  assign phase_b = restart ? PH_COMMAND : phase_r;
  assign pos_b   = restart ? 5'd0 : pos_r;
  assign shift_b = restart ? 32'd0 : shift_r;
  assign acc_b   = restart ? '0 : acc_r;
  assign neg_b   = restart ? 1'b0 : neg_r;
  assign stop_b  = restart ? 1'b0 : stop_r;
  assign ovf_b   = restart ? 1'b0 : ovf_r;
  assign rem_b   = restart ? '0 : rem_r;
  assign idx_b   = restart ? 3'd0 : idx_r;

  assign shift_in = {shift_b[23:0], data_byte};
  assign limit    = (cfg.count > 3'(COMMAND_SLOTS)) ? 3'(COMMAND_SLOTS) : cfg.count;

  always_comb begin
    hit     = 1'b0;
    hit_idx = 3'd0;
    for (int i = COMMAND_SLOTS - 1; i >= 0; i--) begin
      if ((3'(i) < limit) && (cfg.words[i] == shift_in)) begin
        hit     = 1'b1;
        hit_idx = 3'(i);
      end
    end
  end

  assign is_digit = data_byte inside {[lpcf_pkg::CH_ZERO:lpcf_pkg::CH_NINE]};
  assign is_space = data_byte inside {lpcf_pkg::CH_SPACE, [lpcf_pkg::CH_TAB:lpcf_pkg::CH_CR]};
  assign digit    = 4'(data_byte - lpcf_pkg::CH_ZERO);
  assign acc_sum  = (AW'(acc_b) << 3) + (AW'(acc_b) << 1) + AW'(digit);
  assign sum_ovf  = (acc_sum[AW-1:SIZE_WIDTH] != 4'd0);

  always_comb begin
    phase_nxt = phase_b;
    shift_nxt = shift_b;
    acc_nxt   = acc_b;
    neg_nxt   = neg_b;
    stop_nxt  = stop_b;
    ovf_nxt   = ovf_b;
    rem_nxt   = rem_b;
    idx_nxt   = idx_b;
    pv        = 1'b0;
    pl        = 1'b0;
    case (phase_b)
      PH_COMMAND: begin
        shift_nxt = shift_in;
        if (pos_b >= lpcf_pkg::POS_CMD_LAST) begin
          if (hit) begin
            idx_nxt   = hit_idx;
            phase_nxt = PH_SEPARATOR;
          end else begin
            phase_nxt = PH_ERROR;
          end
        end
      end
      PH_SEPARATOR: phase_nxt = PH_SIZE_LEAD;
      PH_SIZE_LEAD, PH_SIZE_DIGITS: begin
        if (data_byte == lpcf_pkg::CH_COLON) begin
          if (ovf_b || (neg_b && (acc_b != '0))) begin
            phase_nxt = PH_ERROR;
          end else begin
            rem_nxt   = acc_b;
            phase_nxt = (acc_b == '0) ? PH_DONE : PH_PAYLOAD;
          end
        end else if (pos_b >= lpcf_pkg::POS_COLON_MAX) begin
          phase_nxt = PH_ERROR;
        end else if (phase_b == PH_SIZE_LEAD) begin
          if (!is_space) begin
            phase_nxt = PH_SIZE_DIGITS;
            if (data_byte == lpcf_pkg::CH_MINUS) begin
              neg_nxt = 1'b1;
            end else if (data_byte == lpcf_pkg::CH_PLUS) begin
              neg_nxt = neg_b;
            end else if (is_digit) begin
              if (!ovf_b) begin
                if (sum_ovf) ovf_nxt = 1'b1;
                else acc_nxt = acc_sum[SIZE_WIDTH-1:0];
              end
            end else begin
              stop_nxt = 1'b1;
            end
          end
        end else if (!stop_b) begin
          if (is_digit) begin
            if (!ovf_b) begin
              if (sum_ovf) ovf_nxt = 1'b1;
              else acc_nxt = acc_sum[SIZE_WIDTH-1:0];
            end
          end else begin
            stop_nxt = 1'b1;
          end
        end
      end
      PH_PAYLOAD: begin
        pv = 1'b1;
        rem_nxt = (rem_b != '0) ? rem_b - 1'b1 : rem_b;
        if (rem_nxt == '0) begin
          pl        = 1'b1;
          phase_nxt = PH_DONE;
        end
      end
      default: phase_nxt = phase_b;
    endcase
  end

  assign pos_nxt = (pos_b < lpcf_pkg::POS_SAT) ? pos_b + 5'd1 : pos_b;
  assign acc_pad = (SIZE_WIDTH + 16)'(acc_nxt);

  always_comb begin
    case (phase_nxt)
      PH_ERROR: frame_st = lpcf_pkg::ST_ERROR;
      PH_DONE:  frame_st = lpcf_pkg::ST_COMPLETE;
      default:  frame_st = lpcf_pkg::ST_RECEIVING;
    endcase
  end

  assign result.frame_status  = frame_st;
  assign result.command_index = (phase_nxt == PH_ERROR) ? 3'd0 : idx_nxt;
  assign result.declared_size = ((phase_nxt == PH_PAYLOAD) || (phase_nxt == PH_DONE))
                                ? acc_pad[15:0] : 16'd0;
  assign result.payload_valid = pv;
  assign result.payload_byte  = pv ? data_byte : 8'd0;
  assign result.payload_last  = pl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_COMMAND;
      pos_r   <= 5'd0;
      shift_r <= 32'd0;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      stop_r  <= 1'b0;
      ovf_r   <= 1'b0;
      rem_r   <= '0;
      idx_r   <= 3'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      shift_r <= shift_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      stop_r  <= stop_nxt;
      ovf_r   <= ovf_nxt;
      rem_r   <= rem_nxt;
      idx_r   <= idx_nxt;
    end
  end

  `LPCF_ASSERT(a_payload_has_rem, clk, !rst_n, (phase_r != PH_PAYLOAD) || (rem_r != '0))
  `LPCF_ASSERT(a_pos_saturates, clk, !rst_n, pos_r <= lpcf_pkg::POS_SAT)
  `LPCF_ASSERT_NEXT(a_done_holds, clk, !rst_n,
    accept && !restart && (phase_r == PH_DONE || phase_r == PH_ERROR), $stable(phase_r))

endmodule

[design/lpcf_outq.sv]
// Two-entry result buffer: output register plus skid slot.
// Depends on lpcf_pkg and the assertion macro header.
`include "length_prefixed_command_frame_parser_unit_assert.svh"
module lpcf_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lpcf_pkg::result_t push_data,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output lpcf_pkg::result_t out_data
);

  lpcf_pkg::result_t head_r;
  lpcf_pkg::result_t skid_r;
  logic              hv_r;
  logic              sv_r;
  logic              pop;

  assign space     = !sv_r;
  assign out_valid = hv_r;
  assign out_data  = head_r;
  assign pop       = hv_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r <= 1'b0;
      sv_r <= 1'b0;
    end else begin
      if (pop && !push) begin
        if (sv_r) begin
          head_r <= skid_r;
          sv_r   <= 1'b0;
        end else begin
          hv_r <= 1'b0;
        end
      end else if (push && !pop) begin
        if (!hv_r) begin
          head_r <= push_data;
          hv_r   <= 1'b1;
        end else begin
          skid_r <= push_data;
          sv_r   <= 1'b1;
        end
      end else if (push && pop) begin
        head_r <= push_data;
      end
    end
  end

  `LPCF_ASSERT(a_skid_needs_head, clk, !rst_n, !sv_r || hv_r)
  `LPCF_ASSERT_NEXT(a_no_push_when_full, clk, !rst_n, sv_r && !pop, sv_r && hv_r)

endmodule

[design/length_prefixed_command_frame_parser_unit.sv]
// Length-prefixed command frame parser, top level: config registers, parser core, result buffer.
// Output: each result is registered in the output buffer before it shows on out_*.
// Throughput: one byte per cycle while in_ready is high, with frame state updated per byte;
// a two-entry result buffer keeps input flowing while one result waits.
// Reset: synchronous, active low; clears command registers, frame state and the result buffer.
module length_prefixed_command_frame_parser_unit #(
  parameter int SIZE_WIDTH    = 16,
  parameter int COMMAND_SLOTS = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_frame_status,
  output logic [2:0]  out_command_index,
  output logic [15:0] out_declared_size,
  output logic        out_payload_valid,
  output logic [7:0]  out_payload_byte,
  output logic        out_payload_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  lpcf_pkg::cfg_t    cfg;
  lpcf_pkg::result_t step_res;
  lpcf_pkg::result_t out_res;
  logic              accept;
  logic              space;

  assign in_ready = space;
  assign accept   = in_valid && space;

  lpcf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lpcf_core #(
    .SIZE_WIDTH    (SIZE_WIDTH),
    .COMMAND_SLOTS (COMMAND_SLOTS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_data_byte),
    .restart   (in_restart),
    .cfg       (cfg),
    .result    (step_res)
  );

  lpcf_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (step_res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  assign out_frame_status  = out_res.frame_status;
  assign out_command_index = out_res.command_index;
  assign out_declared_size = out_res.declared_size;
  assign out_payload_valid = out_res.payload_valid;
  assign out_payload_byte  = out_res.payload_byte;
  assign out_payload_last  = out_res.payload_last;

endmodule
